// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define AST_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hdl/hbi_pkg.sv -----
// ----------------------------------------------------------------------------
// hbi_pkg
// types and constants shared by the bilinear interpolator modules
// ----------------------------------------------------------------------------
package hbi_pkg;

  localparam int MAX_X_POINTS = 64;
  localparam int MAX_Y_POINTS = 64;
  localparam int ITER_LIMIT   = 500;

  // divider handles 49-bit dividend, multiplier 32-bit multiplier
  localparam int DIV_STEPS = 49;
  localparam int MUL_STEPS = 32;

  // configuration register indexes
  localparam logic CFG_X_COUNT = 1'b0;
  localparam logic CFG_Y_COUNT = 1'b1;

  typedef enum logic [1:0] {
    KIND_WR_X  = 2'd0,
    KIND_WR_Y  = 2'd1,
    KIND_WR_G  = 2'd2,
    KIND_QUERY = 2'd3
  } kind_t;

  typedef enum logic {
    MDU_DIV = 1'b0,
    MDU_MUL = 1'b1
  } mdu_op_t;

  typedef struct packed {
    logic    start;
    mdu_op_t op;
  } mdu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mdu_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HUNT_RD,
    ST_HUNT_CMP,
    ST_YCHK_RD,
    ST_YCHK,
    ST_FETCH,
    ST_LOAD,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_MUL_GO,
    ST_MUL_WAIT
  } state_t;

endpackage

// ----- hdl/hunting_bilinear_interpolator.sv -----
// ----------------------------------------------------------------------------
// hunting_bilinear_interpolator
// bilinear table lookup with interval hunting, signed Q16.16
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Write items (x
// breakpoint, y breakpoint, grid cell) leave busy low. A query holds busy
// high until its result: it hunts the x interval one breakpoint at a time,
// checks the y range and hunts the y interval the same way, fetches the four
// corners from the single-port grid memory, then runs three interpolations
// on the shared bit-serial unit (49 divide steps, 32 multiply steps). The
// result shows on interp_value and status for one cycle with done high; the
// receiver cannot stall it, so it must take it in that cycle. An x beyond the
// last breakpoint returns 0 with status 1. Breakpoint and grid stores are not
// cleared by reset and must be written before they are queried.
module hunting_bilinear_interpolator (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind,
  input  logic [5:0]         row_index,
  input  logic [5:0]         col_index,
  input  logic signed [31:0] write_value,
  input  logic signed [31:0] query_x,
  input  logic signed [31:0] query_y,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [6:0]         cfg_data,
  output logic               done,
  output logic signed [31:0] interp_value,
  output logic               status
);
  import hbi_pkg::*;

  state_t state, state_next;

  logic [6:0] x_point_count, y_point_count;
  logic [6:0] xl, yl;
  logic [6:0] last_x, last_y;

  logic signed [31:0] xmem [MAX_X_POINTS];
  logic signed [31:0] ymem [MAX_Y_POINTS];
  logic signed [31:0] gmem [MAX_X_POINTS * MAX_Y_POINTS];
  logic signed [31:0] xr0, xr1, yr0, yr1, gr;
  logic [5:0]  xa0, xa1, ya0, ya1;
  logic [11:0] ga;

  logic signed [31:0] qx, qy;
  logic [6:0]  hi_idx;
  logic [9:0]  moves;
  logic        dim;
  logic [6:0]  ix;
  logic [5:0]  j1, j2;
  logic signed [31:0] xb1, xb2, yb1, yb2;
  logic signed [31:0] g [4];
  logic [2:0]  fk;
  logic [1:0]  ln;
  logic signed [31:0] la, lb, lp1, lp2, lv, tq, r1, r2;

  logic accept;
  logic accept_query;

  // hunt step signals
  logic signed [31:0] h_lo, h_hi, h_v;
  logic [6:0] h_len, h_next, h_found_idx;
  logic [9:0] h_moves;
  logic h_zero, h_in, h_found, h_fail;

  // lerp arithmetic
  logic signed [32:0] den, dif, dd;
  logic signed [48:0] num;
  logic [48:0] num_mag;
  logic [32:0] den_mag, d_mag, t_neg;
  logic [31:0] t_mag;
  logic        q_sign, p_sign;
  logic [48:0] q;
  logic signed [31:0] t_sat;
  logic [47:0] sh;
  logic signed [49:0] adj, lsum;
  logic signed [31:0] lres;

  mdu_req_t    mreq;
  mdu_rsp_t    mrsp;
  logic [48:0] ma;
  logic [32:0] mb;
  logic [63:0] mres;

  hbi_mdu u_mdu (
    .clk    (clk),
    .rst    (rst),
    .req    (mreq),
    .a      (ma),
    .b      (mb),
    .rsp    (mrsp),
    .result (mres)
  );

  assign busy         = (state != ST_IDLE);
  assign accept       = start && !busy;
  assign accept_query = accept && (kind == KIND_QUERY);

  // effective counts clamped to 2..max
  always_comb begin
    xl = (x_point_count < 7'd2) ? 7'd2 :
         (x_point_count > 7'(MAX_X_POINTS)) ? 7'(MAX_X_POINTS) : x_point_count;
    yl = (y_point_count < 7'd2) ? 7'd2 :
         (y_point_count > 7'(MAX_Y_POINTS)) ? 7'(MAX_Y_POINTS) : y_point_count;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      x_point_count <= 7'd2;
      y_point_count <= 7'd2;
    end else if (cfg_we) begin
      if (cfg_index == CFG_X_COUNT) x_point_count <= cfg_data;
      if (cfg_index == CFG_Y_COUNT) y_point_count <= cfg_data;
    end
  end

  // memories: writes on accepted write items, registered reads
  always_ff @(posedge clk) begin
    if (accept && kind == KIND_WR_X) xmem[row_index] <= write_value;
    if (accept && kind == KIND_WR_Y) ymem[col_index] <= write_value;
    if (accept && kind == KIND_WR_G) gmem[{row_index, col_index}] <= write_value;
    xr0 <= xmem[xa0];
    xr1 <= xmem[xa1];
    yr0 <= ymem[ya0];
    yr1 <= ymem[ya1];
    gr  <= gmem[ga];
  end

  // read addresses by state
  always_comb begin
    xa0 = hi_idx[5:0] - 6'd1;
    xa1 = hi_idx[5:0];
    ya0 = hi_idx[5:0] - 6'd1;
    ya1 = hi_idx[5:0];
    ga  = {ix[5:0] - 6'd1, j1};
    case (state)
      ST_YCHK_RD: ya1 = 6'(yl - 7'd1);
      ST_FETCH: begin
        xa0 = ix[5:0] - 6'd1;
        xa1 = ix[5:0];
        ya0 = j1;
        ya1 = j2;
        ga  = {(fk[0] ? ix[5:0] : ix[5:0] - 6'd1), (fk[1] ? j2 : j1)};
      end
      default: ;
    endcase
  end

  // one hunt step on the current interval
  always_comb begin
    h_lo        = dim ? yr0 : xr0;
    h_hi        = dim ? yr1 : xr1;
    h_v         = dim ? qy : qx;
    h_len       = dim ? yl : xl;
    h_zero      = (hi_idx == 7'd0);
    h_in        = (h_lo <= h_v) && (h_v <= h_hi);
    h_next      = (h_hi <= h_v) ? hi_idx + 7'd1 : hi_idx - 7'd1;
    h_moves     = moves + 10'd1;
    h_found     = h_zero || h_in;
    h_fail      = !h_found && ((h_moves > 10'(ITER_LIMIT)) || (h_next >= h_len));
    h_found_idx = h_zero ? 7'd1 : hi_idx;
  end

  // weight and value arithmetic around the shared unit
  always_comb begin
    den     = {lp2[31], lp2} - {lp1[31], lp1};
    dif     = {lv[31], lv} - {lp1[31], lp1};
    num     = {dif, 16'd0};
    num_mag = num[48] ? 49'(-num) : 49'(num);
    den_mag = den[32] ? 33'(-den) : 33'(den);
    q_sign  = num[48] ^ den[32];
    q       = mres[48:0];
    if (!q_sign) t_sat = (q > 49'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(q);
    else         t_sat = (q > 49'h8000_0000) ? 32'sh8000_0000 : 32'(-q);
    dd      = {lb[31], lb} - {la[31], la};
    d_mag   = dd[32] ? 33'(-dd) : 33'(dd);
    t_neg   = -{tq[31], tq};
    t_mag   = tq[31] ? t_neg[31:0] : tq[31:0];
    p_sign  = tq[31] ^ dd[32];
    sh      = mres[63:16];
    adj     = p_sign ? -$signed({2'b00, sh}) : $signed({2'b00, sh});
    lsum    = {{18{la[31]}}, la} + adj;
    if (lsum > 50'sh7FFF_FFFF)       lres = 32'sh7FFF_FFFF;
    else if (lsum < -50'sh8000_0000) lres = 32'sh8000_0000;
    else                             lres = lsum[31:0];
  end

  // shared unit requests
  always_comb begin
    mreq.start = 1'b0;
    mreq.op    = MDU_DIV;
    ma         = num_mag;
    mb         = den_mag;
    case (state)
      ST_DIV_GO: mreq.start = (den != 33'sd0);
      ST_MUL_GO: begin
        mreq.start = 1'b1;
        mreq.op    = MDU_MUL;
        ma         = {17'd0, t_mag};
        mb         = d_mag;
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (accept_query) state_next = ST_HUNT_RD;
      ST_HUNT_RD:  state_next = ST_HUNT_CMP;
      ST_HUNT_CMP: begin
        if (h_found)     state_next = dim ? ST_FETCH : ST_YCHK_RD;
        else if (h_fail) state_next = ST_IDLE;
        else             state_next = ST_HUNT_RD;
      end
      ST_YCHK_RD:  state_next = ST_YCHK;
      ST_YCHK:     state_next = (yr1 < qy) ? ST_FETCH : ST_HUNT_RD;
      ST_FETCH:    if (fk == 3'd4) state_next = ST_LOAD;
      ST_LOAD:     state_next = ST_DIV_GO;
      ST_DIV_GO:   state_next = (den == 33'sd0) ? ST_MUL_GO : ST_DIV_WAIT;
      ST_DIV_WAIT: if (mrsp.done) state_next = ST_MUL_GO;
      ST_MUL_GO:   state_next = ST_MUL_WAIT;
      ST_MUL_WAIT: if (mrsp.done) state_next = (ln == 2'd2) ? ST_IDLE : ST_LOAD;
      default:     state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      last_x <= 7'd1;
      last_y <= 7'd1;
      done   <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (state == ST_HUNT_CMP && h_found) begin
        if (dim) last_y <= h_found_idx;
        else     last_x <= h_found_idx;
      end
      if (state == ST_HUNT_CMP && h_fail) done <= 1'b1;
      if (state == ST_MUL_WAIT && mrsp.done && ln == 2'd2) done <= 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        qx     <= query_x;
        qy     <= query_y;
        hi_idx <= (last_x >= xl) ? xl - 7'd1 : last_x;
        moves  <= '0;
        dim    <= 1'b0;
      end
      ST_HUNT_CMP: begin
        if (h_found) begin
          if (dim) begin
            j1 <= 6'(h_found_idx - 7'd1);
            j2 <= h_found_idx[5:0];
          end else begin
            ix <= h_found_idx;
          end
          fk <= '0;
        end else if (h_fail) begin
          interp_value <= '0;
          status       <= 1'b1;
        end else begin
          hi_idx <= h_next;
          moves  <= h_moves;
        end
      end
      ST_YCHK: begin
        fk <= '0;
        if (yr1 < qy) begin
          j1 <= 6'(yl - 7'd1);
          j2 <= '0;
        end else begin
          hi_idx <= (last_y >= yl) ? yl - 7'd1 : last_y;
          moves  <= '0;
          dim    <= 1'b1;
        end
      end
      ST_FETCH: begin
        fk <= fk + 3'd1;
        if (fk == 3'd1) begin
          xb1 <= xr0;
          xb2 <= xr1;
          yb1 <= yr0;
          yb2 <= yr1;
        end
        if (fk != 3'd0) g[2'(fk - 3'd1)] <= gr;
        ln <= '0;
      end
      ST_LOAD: begin
        case (ln)
          2'd0: begin
            la <= g[0]; lb <= g[1]; lp1 <= xb1; lp2 <= xb2; lv <= qx;
          end
          2'd1: begin
            la <= g[2]; lb <= g[3]; lp1 <= xb1; lp2 <= xb2; lv <= qx;
          end
          default: begin
            la <= r1; lb <= r2; lp1 <= yb1; lp2 <= yb2; lv <= qy;
          end
        endcase
      end
      ST_DIV_GO:   if (den == 33'sd0) tq <= '0;
      ST_DIV_WAIT: if (mrsp.done) tq <= t_sat;
      ST_MUL_WAIT: begin
        if (mrsp.done) begin
          case (ln)
            2'd0:    r1 <= lres;
            2'd1:    r2 <= lres;
            default: begin
              interp_value <= lres;
              status       <= 1'b0;
            end
          endcase
          ln <= ln + 2'd1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- hdl/hbi_mdu.sv -----
// ----------------------------------------------------------------------------
// hbi_mdu
// shared bit-serial unit: restoring unsigned divide or shift-add multiply
// ----------------------------------------------------------------------------
module hbi_mdu (
  input  logic             clk,
  input  logic             rst,
  input  hbi_pkg::mdu_req_t req,
  input  logic [48:0]      a,
  input  logic [32:0]      b,
  output hbi_pkg::mdu_rsp_t rsp,
  output logic [63:0]      result
);
  import hbi_pkg::*;

  mdu_op_t     op;
  logic [5:0]  cnt;
  logic        busy;
  logic        done;
  logic [32:0] bb;
  logic [32:0] rem;
  logic [48:0] quo;
  logic [33:0] hi;
  logic [31:0] lo;

  logic [33:0] shifted;
  logic        fits;
  logic [33:0] diff;
  logic [33:0] sum;

  // one divide step or one multiply step
  always_comb begin
    shifted = {rem, quo[48]};
    fits    = shifted >= {1'b0, bb};
    diff    = shifted - {1'b0, bb};
    sum     = hi + (lo[0] ? {1'b0, bb} : 34'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      op   <= MDU_DIV;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        op   <= req.op;
        busy <= 1'b1;
        cnt  <= (req.op == MDU_DIV) ? 6'(DIV_STEPS) : 6'(MUL_STEPS);
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      bb  <= b;
      rem <= '0;
      quo <= a;
      hi  <= '0;
      lo  <= a[31:0];
    end else if (busy) begin
      if (op == MDU_DIV) begin
        rem <= fits ? diff[32:0] : shifted[32:0];
        quo <= {quo[47:0], fits};
      end else begin
        hi <= {1'b0, sum[33:1]};
        lo <= {sum[0], lo[31:1]};
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign result   = (op == MDU_DIV) ? {15'd0, quo} : {hi[31:0], lo};

endmodule

// ----- hdl/hbi_checker.sv -----
// ----------------------------------------------------------------------------
// hbi_checker
// port-level checks on the interpolator, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hbi_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic [1:0]         kind,
  input logic               done,
  input logic signed [31:0] interp_value,
  input logic               status
);
  import hbi_pkg::*;

  // a result only closes a query that kept the block busy
  `AST_IMP(a_done_after_busy, done, $past(busy))
  // the block is free again once the result is out
  `AST_IMP(a_done_idle, done, !busy)
  // an error result carries a zero value
  `AST_IMP(a_err_zero, done && status, interp_value == 32'sd0)
  // a taken query occupies the block
  `AST_NEXT(a_query_busy, start && !busy && kind == KIND_QUERY, busy)

endmodule

bind hunting_bilinear_interpolator hbi_checker u_hbi_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .kind         (kind),
  .done         (done),
  .interp_value (interp_value),
  .status       (status)
);

// ----- bench/tb_hunting_bilinear_interpolator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hunting_bilinear_interpolator
// Loads breakpoint lists and grids, then runs hunted bilinear queries across
// several table sizes. Every query result is predicted in the bench and
// compared field by field, in order, with what the block returns.
// ----------------------------------------------------------------------------
module tb_hunting_bilinear_interpolator;
  import hbi_pkg::*;

  typedef struct {
    kind_t       kind;
    logic [5:0]  row;
    logic [5:0]  col;
    logic signed [31:0] wval;
    logic signed [31:0] qx;
    logic signed [31:0] qy;
  } lut_item_t;

  typedef struct {
    logic signed [31:0] value;
    logic               err;
  } lut_result_t;

  localparam longint CYCLE_LIMIT = 3000000;
  localparam int     DRAIN_CYCLES = 600;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] kind = '0;
  logic [5:0] row_index = '0;
  logic [5:0] col_index = '0;
  logic signed [31:0] write_value = '0;
  logic signed [31:0] query_x = '0;
  logic signed [31:0] query_y = '0;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_X_COUNT;
  logic [6:0] cfg_data = '0;
  logic done;
  logic signed [31:0] interp_value;
  logic status;

  hunting_bilinear_interpolator i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .row_index(row_index), .col_index(col_index), .write_value(write_value),
    .query_x(query_x), .query_y(query_y), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done),
    .interp_value(interp_value), .status(status)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic signed [31:0] xbp [MAX_X_POINTS];
  logic signed [31:0] ybp [MAX_Y_POINTS];
  logic signed [31:0] grid [MAX_X_POINTS][MAX_Y_POINTS];
  int unsigned x_hint, y_hint;
  int unsigned x_count_reg, y_count_reg;

  lut_item_t   pending_items [$];
  lut_result_t expected_results [$];
  int          mismatches = 0;
  longint      cycles = 0;
  bit          stim_done = 1'b0;

  function automatic longint clamp32(longint v);
    if (v < -64'sd2147483648) return -64'sd2147483648;
    if (v > 64'sd2147483647) return 64'sd2147483647;
    return v;
  endfunction

  function automatic int unsigned used_points(int unsigned c);
    if (c < 2) return 2;
    if (c > 64) return 64;
    return c;
  endfunction

  // interval search stepping one breakpoint at a time, 0 on failure
  function automatic bit find_interval(bit use_y, int unsigned len, longint v,
                                       int unsigned from, output int unsigned hi);
    int unsigned i;
    int unsigned moves;
    longint lo_bp, hi_bp;
    i = (from >= len) ? len - 1 : from;
    moves = 0;
    hi = 1;
    forever begin
      if (i == 0) begin
        hi = 1;
        return 1'b1;
      end
      lo_bp = use_y ? ybp[i-1] : xbp[i-1];
      hi_bp = use_y ? ybp[i] : xbp[i];
      if (lo_bp <= v && v <= hi_bp) begin
        hi = i;
        return 1'b1;
      end
      if (hi_bp <= v) i++;
      else i--;
      moves++;
      if (moves > ITER_LIMIT) return 1'b0;
      if (i >= len) return 1'b0;
    end
  endfunction

  function automatic longint blend(longint va, longint vb, longint p1, longint p2,
                                   longint v);
    longint den, t, p;
    den = p2 - p1;
    t = 0;
    if (den != 0) t = ((v - p1) * 65536) / den;
    t = clamp32(t);
    p = t * (vb - va);
    return clamp32(va + p / 65536);
  endfunction

  // apply one item to the predictor, pushing any expected result
  function automatic void predict_item(lut_item_t it);
    int unsigned xl, yl, ix, jy, i1, i2, j1, j2;
    longint r1, r2;
    lut_result_t res;
    case (it.kind)
      KIND_WR_X: xbp[it.row] = it.wval;
      KIND_WR_Y: ybp[it.col] = it.wval;
      KIND_WR_G: grid[it.row][it.col] = it.wval;
      default: begin
        xl = used_points(x_count_reg);
        yl = used_points(y_count_reg);
        res.value = '0;
        res.err = 1'b1;
        if (find_interval(1'b0, xl, it.qx, x_hint, ix)) begin
          x_hint = ix;
          i1 = ix - 1;
          i2 = ix;
          if (ybp[yl-1] < it.qy) begin
            j1 = yl - 1;
            j2 = 0;
            res.err = 1'b0;
          end else if (find_interval(1'b1, yl, it.qy, y_hint, jy)) begin
            y_hint = jy;
            j1 = jy - 1;
            j2 = jy;
            res.err = 1'b0;
          end
          if (!res.err) begin
            r1 = blend(grid[i1][j1], grid[i2][j1], xbp[i1], xbp[i2], it.qx);
            r2 = blend(grid[i1][j2], grid[i2][j2], xbp[i1], xbp[i2], it.qx);
            res.value = 32'(blend(r1, r2, ybp[j1], ybp[j2], it.qy));
          end
        end
        expected_results.push_back(res);
      end
    endcase
  endfunction

  // driver: bursts with random gaps, holds off while hold_sender is set
  int  gap_left = 0;
  int  burst_left = 0;
  bit  hold_sender = 1'b0;
  lut_item_t cur;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_item(cur);
      end
      if (start && busy) begin
        // keep presenting the same item
      end else if (pending_items.size() > 0 && !hold_sender && gap_left == 0) begin
        cur = pending_items.pop_front();
        kind <= cur.kind;
        row_index <= cur.row;
        col_index <= cur.col;
        write_value <= cur.wval;
        query_x <= cur.qx;
        query_y <= cur.qy;
        start <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        start <= 1'b0;
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // monitor
  lut_result_t want;
  always @(posedge clk) begin
    if (!rst) begin
      cycles++;
      if (done) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result value=%0d status=%0b", interp_value, status);
        end else begin
          want = expected_results.pop_front();
          if (interp_value !== want.value || status !== want.err) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: value exp %0d got %0d, status exp %0b got %0b",
                       want.value, interp_value, want.err, status);
          end
        end
      end
      if (cycles > CYCLE_LIMIT) begin
        $display("tb_hunting_bilinear_interpolator failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic lut_item_t mk(kind_t k, int r, int c, logic [31:0] w,
                                   logic [31:0] x, logic [31:0] y);
    lut_item_t it;
    it.kind = k;
    it.row = r[5:0];
    it.col = c[5:0];
    it.wval = w;
    it.qx = x;
    it.qy = y;
    return it;
  endfunction

  function automatic logic [31:0] rnd32();
    return $urandom;
  endfunction

  task automatic idle_wait();
    wait (pending_items.size() == 0);
    @(posedge clk);
    while (start || busy || expected_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [6:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_X_COUNT) x_count_reg = val;
    else y_count_reg = val;
  endtask

  // load ascending breakpoints and a random grid covering the first n entries
  task automatic load_table(int nx, int ny, bit wide);
    longint acc;
    int step_max;
    step_max = wide ? 32'h0800_0000 : 32'h0004_0000;
    acc = wide ? -64'sd2147483000 : -$urandom_range(0, 32'h0010_0000);
    for (int i = 0; i < nx; i++) begin
      pending_items.push_back(mk(KIND_WR_X, i, $urandom, 32'(acc), rnd32(), rnd32()));
      acc += $urandom_range(1, step_max);
      if (acc > 64'sd2147483647) acc = 64'sd2147483647 - (nx - i);
    end
    acc = wide ? -64'sd2147483000 : -$urandom_range(0, 32'h0010_0000);
    for (int j = 0; j < ny; j++) begin
      pending_items.push_back(mk(KIND_WR_Y, $urandom, j, 32'(acc), rnd32(), rnd32()));
      acc += $urandom_range(1, step_max);
      if (acc > 64'sd2147483647) acc = 64'sd2147483647 - (ny - j);
    end
    for (int i = 0; i < nx; i++)
      for (int j = 0; j < ny; j++)
        pending_items.push_back(mk(KIND_WR_G, i, j,
          ($urandom_range(0, 7) == 0) ? rnd32() : 32'($signed($urandom_range(0, 32'h0040_0000))
            - 32'sh0020_0000), rnd32(), rnd32()));
  endtask

  // a coordinate near the table span, sometimes far outside
  function automatic logic [31:0] pick_coord(bit use_y, int n);
    int k;
    longint lo, hi;
    k = $urandom_range(0, n - 1);
    lo = use_y ? ybp[0] : xbp[0];
    hi = use_y ? ybp[n-1] : xbp[n-1];
    case ($urandom_range(0, 9))
      0: return rnd32();
      1: return 32'(lo - $urandom_range(0, 32'h0002_0000));
      2: return 32'(hi + $urandom_range(1, 32'h0001_0000));
      3: return use_y ? ybp[k] : xbp[k];
      default: return 32'(lo + longint'($urandom) % (hi - lo + 1));
    endcase
  endfunction

  int queries;
  int sizes [5] = '{2, 3, 5, 9, 16};

  initial begin
    for (int i = 0; i < MAX_X_POINTS; i++) begin
      xbp[i] = '0;
      ybp[i] = '0;
      for (int j = 0; j < MAX_Y_POINTS; j++) grid[i][j] = '0;
    end
    x_hint = 1;
    y_hint = 1;
    x_count_reg = 2;
    y_count_reg = 2;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: minimal table, extremes of values, y below and above table
    pending_items.push_back(mk(KIND_WR_X, 0, 0, 32'sh8000_0000, 0, 0));
    pending_items.push_back(mk(KIND_WR_X, 1, 63, 32'sh7fff_ffff, 0, 0));
    pending_items.push_back(mk(KIND_WR_Y, 63, 0, 32'sh0000_0000, 0, 0));
    pending_items.push_back(mk(KIND_WR_Y, 0, 1, 32'sh0001_0000, 0, 0));
    pending_items.push_back(mk(KIND_WR_G, 0, 0, 32'sh7fff_ffff, 0, 0));
    pending_items.push_back(mk(KIND_WR_G, 0, 1, 32'sh8000_0000, 0, 0));
    pending_items.push_back(mk(KIND_WR_G, 1, 0, 32'sh8000_0000, 0, 0));
    pending_items.push_back(mk(KIND_WR_G, 1, 1, 32'sh7fff_ffff, 0, 0));
    pending_items.push_back(mk(KIND_QUERY, 0, 0, 0, 32'sh0000_0000, 32'sh0000_8000));
    pending_items.push_back(mk(KIND_QUERY, 63, 63, 32'hffff_ffff, 32'sh8000_0000,
                               32'sh8000_0000));
    pending_items.push_back(mk(KIND_QUERY, 0, 0, 0, 32'sh7fff_ffff, 32'sh0001_0000));
    pending_items.push_back(mk(KIND_QUERY, 0, 0, 0, 32'sh1234_5678, 32'sh7fff_ffff));
    pending_items.push_back(mk(KIND_QUERY, 0, 0, 0, 32'shffff_0000, 32'shffff_ffff));
    // equal breakpoints give a zero span
    pending_items.push_back(mk(KIND_WR_Y, 0, 1, 32'sh0000_0000, 0, 0));
    pending_items.push_back(mk(KIND_QUERY, 0, 0, 0, 32'sh0000_1000, 32'sh0000_0000));
    pending_items.push_back(mk(KIND_QUERY, 0, 0, 0, 32'sh0000_1000, 32'shffff_0000));
    idle_wait();

    // counts below the minimum and above the maximum
    write_cfg(CFG_X_COUNT, 7'd0);
    write_cfg(CFG_Y_COUNT, 7'd127);
    load_table(2, 64, 1'b1);
    idle_wait();
    for (int q = 0; q < 20; q++)
      pending_items.push_back(mk(KIND_QUERY, $urandom, $urandom, rnd32(),
                                 pick_coord(1'b0, 2), pick_coord(1'b1, 64)));
    idle_wait();
    write_cfg(CFG_X_COUNT, 7'd127);
    write_cfg(CFG_Y_COUNT, 7'd1);
    load_table(64, 2, 1'b1);
    idle_wait();
    for (int q = 0; q < 20; q++)
      pending_items.push_back(mk(KIND_QUERY, $urandom, $urandom, rnd32(),
                                 pick_coord(1'b0, 64), pick_coord(1'b1, 2)));
    idle_wait();

    // random phases over a range of table sizes, mostly small
    queries = 0;
    for (int ph = 0; ph < 7; ph++) begin
      int nx, ny;
      nx = sizes[$urandom_range(0, 4)];
      ny = sizes[$urandom_range(0, 4)];
      write_cfg(CFG_X_COUNT, 7'(nx));
      write_cfg(CFG_Y_COUNT, 7'(ny));
      if (nx * ny <= 100) load_table(nx, ny, ph[0]);
      else begin
        load_table(nx, ny, 1'b0);
      end
      idle_wait();
      for (int q = 0; q < 50; q++) begin
        if ($urandom_range(0, 9) == 0)
          pending_items.push_back(mk(KIND_WR_G, $urandom_range(0, nx - 1),
                                     $urandom_range(0, ny - 1), rnd32(), rnd32(), rnd32()));
        else
          pending_items.push_back(mk(KIND_QUERY, $urandom, $urandom, rnd32(),
                                     pick_coord(1'b0, nx), pick_coord(1'b1, ny)));
        queries++;
        if (q == 30) begin
          // hold the sender until every result is back
          wait (pending_items.size() == 0);
          hold_sender = 1'b1;
          while (busy || start || expected_results.size() > 0) @(posedge clk);
          hold_sender = 1'b0;
        end
      end
      idle_wait();
    end

    stim_done = 1'b1;
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb_hunting_bilinear_interpolator passed");
    end else begin
      $display("tb_hunting_bilinear_interpolator failed");
    end
    $finish;
  end

endmodule
